### design/mtfr_pkg.sv
// shared types and constants for the magic-word framed byte receiver
// no dependencies; imported by every module of the block
package mtfr_pkg;

  localparam int MAGIC_BYTES_DEF     = 4;
  localparam int MAX_FRAME_BYTES_DEF = 64;

  // register file layout
  localparam int CFG_DATA_W    = 40;
  localparam int CFG_INDEX_W   = 3;
  localparam int LEN_W         = 7;
  localparam int MAGIC_W       = 32;
  localparam int MAGIC_REG_BYTES = MAGIC_W / 8;
  localparam int TYPE_CODES_W  = 40;
  localparam int POS_W         = 6;

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd16;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_WORD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TYPE_CODES = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_AIM_LEN    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOC_LEN    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_VEL_LEN    = 3'd4;

  typedef enum logic [2:0] {
    MODE_HUNT = 3'd0,
    MODE_TYPE = 3'd1,
    MODE_AIM  = 3'd2,
    MODE_LOC  = 3'd3,
    MODE_VEL  = 3'd4
  } parse_mode_t;

  typedef enum logic [2:0] {
    ST_NOMATCH = 3'd0,
    ST_MAGIC   = 3'd1,
    ST_TYPE    = 3'd2,
    ST_PAYLOAD = 3'd3,
    ST_DONE    = 3'd4,
    ST_XFORM   = 3'd5,
    ST_ODO     = 3'd6,
    ST_BADTYPE = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    KIND_AIM  = 2'd0,
    KIND_LOC  = 2'd1,
    KIND_VEL  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef struct packed {
    logic [MAGIC_W-1:0]      magic_word;
    logic [TYPE_CODES_W-1:0] type_codes;
    logic [LEN_W-1:0]        aim_len;
    logic [LEN_W-1:0]        loc_len;
    logic [LEN_W-1:0]        vel_len;
  } cfg_t;

  typedef struct packed {
    status_t          status;
    logic [7:0]       data_byte;
    logic [POS_W-1:0] position;
    kind_t            kind;
    logic             last;
  } result_t;

endpackage

### design/magic_typed_frame_receiver_unit.sv
// Magic-word framed byte receiver. Takes one serial byte per item and returns
// exactly one result item per byte: status, the byte, its frame offset, the
// frame kind and a last flag. Throughput is one item per clock cycle while the
// result is not stalled; each byte sits in the input register, then the
// combinational parse step loads the result register. A stalled
// result holds the result register and stalls the input once the input
// register is also full. Configuration is written through
// cfg_we / cfg_index / cfg_data; the user must do so only while no item
// is in flight, as the block itself does not enforce this.
// depends on mtfr_pkg, mtfr_cfg and mtfr_parser
module magic_typed_frame_receiver_unit #(
  parameter int MAGIC_BYTES     = mtfr_pkg::MAGIC_BYTES_DEF,
  parameter int MAX_FRAME_BYTES = mtfr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mtfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mtfr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       out_status,
  output logic [7:0]                       out_data_byte,
  output logic [mtfr_pkg::POS_W-1:0]       out_position,
  output logic [1:0]                       out_frame_kind,
  output logic                             out_frame_last
);
  import mtfr_pkg::*;

  cfg_t    cfg;
  result_t step_res;
  result_t res_r;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       out_valid_r, out_valid_nxt;
  logic       advance;
  logic       in_take;

  mtfr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mtfr_parser #(
    .MAGIC_BYTES     (MAGIC_BYTES),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .rx_byte (s1_byte_r),
    .cfg     (cfg),
    .res     (step_res)
  );

  // the held item moves into the result register when that slot frees up
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_rx_byte;
    end
    if (advance) begin
      res_r <= step_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = res_r.status;
  assign out_data_byte  = res_r.data_byte;
  assign out_position   = res_r.position;
  assign out_frame_kind = res_r.kind;
  assign out_frame_last = res_r.last;

endmodule

### design/mtfr_cfg.sv
// configuration register file: start word, type codes and frame lengths
// depends on mtfr_pkg
module mtfr_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mtfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mtfr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output mtfr_pkg::cfg_t                   cfg
);
  import mtfr_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MAGIC_WORD: cfg_nxt.magic_word = cfg_data[MAGIC_W-1:0];
        CFG_TYPE_CODES: cfg_nxt.type_codes = cfg_data[TYPE_CODES_W-1:0];
        CFG_AIM_LEN:    cfg_nxt.aim_len    = cfg_data[LEN_W-1:0];
        CFG_LOC_LEN:    cfg_nxt.loc_len    = cfg_data[LEN_W-1:0];
        CFG_VEL_LEN:    cfg_nxt.vel_len    = cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic_word <= '0;
      cfg_r.type_codes <= '0;
      cfg_r.aim_len    <= LEN_RESET;
      cfg_r.loc_len    <= LEN_RESET;
      cfg_r.vel_len    <= LEN_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### design/mtfr_parser.sv
// frame parser: parse mode and byte index, one state step per item
// depends on mtfr_pkg; configuration comes from mtfr_cfg
module mtfr_parser #(
  parameter int MAGIC_BYTES     = mtfr_pkg::MAGIC_BYTES_DEF,
  parameter int MAX_FRAME_BYTES = mtfr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [7:0]        rx_byte,
  input  mtfr_pkg::cfg_t    cfg,
  output mtfr_pkg::result_t res
);
  import mtfr_pkg::*;

  // index must hold the type position and any clamped length
  localparam int IDX_W = $clog2(MAX_FRAME_BYTES + MAGIC_BYTES + 2);
  localparam int CW    = IDX_W + 8;
  localparam logic [CW-1:0] MAGIC_C = CW'(MAGIC_BYTES);
  localparam logic [CW-1:0] MAX_C   = CW'(MAX_FRAME_BYTES);

  parse_mode_t      mode_r, mode_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic [CW-1:0] pos_w;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] hunt_idx;
  logic [CW-1:0] hunt_inc;
  logic [7:0]    magic_byte;
  kind_t         cur_kind;
  logic [LEN_W-1:0] raw_len;
  logic [CW-1:0] len_clamp;
  logic          hit_aim, hit_loc, hit_vel, hit_xf, hit_odo;

  assign pos_w    = CW'(idx_r);
  assign idx_inc  = pos_w + CW'(1);
  assign hunt_idx = (pos_w >= MAGIC_C) ? '0 : pos_w;
  assign hunt_inc = hunt_idx + CW'(1);

  // start-word bytes past the register read as zero
  always_comb begin
    if (hunt_idx < CW'(MAGIC_REG_BYTES)) begin
      magic_byte = cfg.magic_word[hunt_idx[1:0]*8 +: 8];
    end else begin
      magic_byte = 8'h00;
    end
  end

  always_comb begin
    case (mode_r)
      MODE_AIM: cur_kind = KIND_AIM;
      MODE_LOC: cur_kind = KIND_LOC;
      MODE_VEL: cur_kind = KIND_VEL;
      default:  cur_kind = KIND_NONE;
    endcase
  end

  always_comb begin
    case (cur_kind)
      KIND_AIM: raw_len = cfg.aim_len;
      KIND_LOC: raw_len = cfg.loc_len;
      default:  raw_len = cfg.vel_len;
    endcase
  end

  assign len_clamp = (CW'(raw_len) > MAX_C) ? MAX_C : CW'(raw_len);

  assign hit_aim = (rx_byte == cfg.type_codes[7:0]);
  assign hit_loc = (rx_byte == cfg.type_codes[15:8]);
  assign hit_vel = (rx_byte == cfg.type_codes[23:16]);
  assign hit_xf  = (rx_byte == cfg.type_codes[31:24]);
  assign hit_odo = (rx_byte == cfg.type_codes[39:32]);

  always_comb begin
    mode_nxt      = mode_r;
    idx_nxt       = idx_r;
    res.status    = ST_NOMATCH;
    res.data_byte = rx_byte;
    res.position  = pos_w[POS_W-1:0];
    res.kind      = KIND_NONE;
    res.last      = 1'b0;
    case (mode_r)
      MODE_TYPE: begin
        // first matching code wins: aim, localization, velocity, queries
        if (hit_aim || hit_loc || hit_vel) begin
          idx_nxt    = idx_inc[IDX_W-1:0];
          res.status = ST_TYPE;
          if (hit_aim) begin
            mode_nxt = MODE_AIM;
            res.kind = KIND_AIM;
          end else if (hit_loc) begin
            mode_nxt = MODE_LOC;
            res.kind = KIND_LOC;
          end else begin
            mode_nxt = MODE_VEL;
            res.kind = KIND_VEL;
          end
        end else begin
          idx_nxt  = '0;
          mode_nxt = MODE_HUNT;
          if (hit_xf) begin
            res.status = ST_XFORM;
          end else if (hit_odo) begin
            res.status = ST_ODO;
          end else begin
            res.status = ST_BADTYPE;
          end
        end
      end
      MODE_AIM, MODE_LOC, MODE_VEL: begin
        res.kind = cur_kind;
        if (idx_inc >= len_clamp) begin
          idx_nxt    = '0;
          mode_nxt   = MODE_HUNT;
          res.status = ST_DONE;
          res.last   = 1'b1;
        end else begin
          idx_nxt    = idx_inc[IDX_W-1:0];
          res.status = ST_PAYLOAD;
        end
      end
      default: begin
        mode_nxt = MODE_HUNT;
        if (rx_byte == magic_byte) begin
          idx_nxt      = hunt_inc[IDX_W-1:0];
          res.status   = ST_MAGIC;
          res.position = hunt_idx[POS_W-1:0];
          if (hunt_inc >= MAGIC_C) begin
            mode_nxt = MODE_TYPE;
          end
        end else begin
          // the failing byte is not retried as a first byte
          idx_nxt      = '0;
          res.position = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HUNT;
      idx_r  <= '0;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      idx_r  <= idx_nxt;
    end
  end

  a_hunt_idx: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_HUNT |-> pos_w < MAGIC_C)
    else $error("hunt index past start word");

  a_type_idx: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_TYPE |-> pos_w == MAGIC_C)
    else $error("type byte at wrong offset");

  a_frame_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_AIM || mode_r == MODE_LOC || mode_r == MODE_VEL)
      |-> pos_w > MAGIC_C)
    else $error("frame byte inside start word");

  a_last_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.last |=> mode_r == MODE_HUNT && idx_r == '0)
    else $error("no return to hunting after last frame byte");

endmodule
